FILE: hdl/ppws_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ppws_pkg;

    // Field widths.
    localparam int WIDTH_W  = 23;
    localparam int MEAN_W   = 17;
    localparam int SPEED_W  = 24;
    localparam int COUNT_W  = 4;
    localparam int SUM_W    = 20;
    localparam int GAIN_W   = 20;
    localparam int OFFSET_W = 16;

    // Configuration port.
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // Register indexes, taken from paddr[2].
    localparam logic REG_GAIN   = 1'b0;
    localparam logic REG_OFFSET = 1'b1;

    localparam logic [GAIN_W-1:0]   GAIN_RESET   = 20'd52363;
    localparam logic [OFFSET_W-1:0] OFFSET_RESET = 16'd281;

    localparam int WINDOW_READINGS_DEF = 8;

    // Frequency in mHz is FREQ_NUM / width; it lies in 100..100000 mHz
    // exactly when the width lies in WIDTH_MIN..WIDTH_MAX.
    localparam int DIV_N_W = 29;
    localparam int DIV_D_W = WIDTH_W;
    localparam logic [DIV_N_W-1:0] FREQ_NUM  = 29'd500000000;
    localparam logic [WIDTH_W-1:0] WIDTH_MIN = 23'd5000;
    localparam logic [WIDTH_W-1:0] WIDTH_MAX = 23'd5000000;
    localparam logic [MEAN_W-1:0]  FREQ_MAX  = 17'd100000;

    // Speed: floor(acc * 36 / 655360) = floor(floor(acc * 9 / 2^15) / 5).
    // The divide by five is a multiply by a rounded-up reciprocal and a
    // shift, which is exact for any dividend of up to 32 bits.
    localparam int ACC_W       = 38;
    localparam int SCALE_SHIFT = 15;
    localparam int SCALED_W    = 27;
    localparam int RECIP_W     = 32;
    localparam logic [RECIP_W-1:0] DIV5_RECIP = 32'hCCCCCCCD;
    localparam int DIV5_SHIFT  = 34;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    typedef struct packed {
        logic [WIDTH_W-1:0] width;
        logic               in_range;
        logic               last;
    } t_job;

    typedef struct packed {
        logic [GAIN_W-1:0]   gain;
        logic [OFFSET_W-1:0] offset;
    } t_cfg;

endpackage

`default_nettype wire

FILE: hdl/ppws_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ppws_in_if;
    logic                           valid;
    logic                           ready;
    logic [ppws_pkg::WIDTH_W-1:0]   pulse_width_us;

    modport source (output valid, output pulse_width_us, input ready);
    modport sink (input valid, input pulse_width_us, output ready);
endinterface

interface ppws_out_if;
    logic                           valid;
    logic                           ready;
    logic [ppws_pkg::MEAN_W-1:0]    mean_freq_mhz;
    logic [ppws_pkg::SPEED_W-1:0]   speed_milli_kmh;
    logic [ppws_pkg::COUNT_W-1:0]   valid_readings;

    modport source (output valid, output mean_freq_mhz, output speed_milli_kmh,
                    output valid_readings, input ready);
    modport sink (input valid, input mean_freq_mhz, input speed_milli_kmh,
                  input valid_readings, output ready);
endinterface

`default_nettype wire

FILE: hdl/ppws_front.sv
`timescale 1ns / 1ps
`default_nettype none

module ppws_front #(
    parameter int WINDOW_READINGS = ppws_pkg::WINDOW_READINGS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    ppws_in_if.sink           i_pulse,
    input  wire logic         i_full,
    output ppws_pkg::t_job    o_job,
    output logic              o_push
);

    localparam int IDX_W = (WINDOW_READINGS > 1) ? $clog2(WINDOW_READINGS) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW_READINGS - 1);

    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] n_idx;
    logic             w_accept;
    logic             w_last;
    logic             w_in_range;

    assign i_pulse.ready = !i_full;
    assign w_accept      = i_pulse.valid && !i_full;
    assign w_last        = (r_idx == IDX_LAST);
    assign w_in_range    = (i_pulse.pulse_width_us >= ppws_pkg::WIDTH_MIN)
                        && (i_pulse.pulse_width_us <= ppws_pkg::WIDTH_MAX);

    // Out-of-range readings only matter when they close a window.
    assign o_push         = w_accept && (w_in_range || w_last);
    assign o_job.width    = i_pulse.pulse_width_us;
    assign o_job.in_range = w_in_range;
    assign o_job.last     = w_last;

    assign n_idx = w_last ? '0 : r_idx + IDX_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (w_accept) begin
            r_idx <= n_idx;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/ppws_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module ppws_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  ppws_pkg::t_job      i_job,
    input  wire logic           i_pop,
    output ppws_pkg::t_job      o_job,
    output logic                o_full,
    output logic                o_empty
);

    localparam int AW = ppws_pkg::QUEUE_AW;

    ppws_pkg::t_job r_mem [ppws_pkg::QUEUE_DEPTH];
    logic [AW-1:0]  r_wr;
    logic [AW-1:0]  r_rd;
    logic [AW:0]    r_count;
    logic           w_push;
    logic           w_pop;

    assign o_full  = (r_count == (AW+1)'(ppws_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + AW'(1);
            end
            if (w_pop) begin
                r_rd <= r_rd + AW'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + (AW+1)'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - (AW+1)'(1);
            end
        end
    end

endmodule

`default_nettype wire

FILE: hdl/ppws_div.sv
`timescale 1ns / 1ps
`default_nettype none

module ppws_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [ppws_pkg::DIV_N_W-1:0]  i_dividend,
    input  wire logic [ppws_pkg::DIV_D_W-1:0]  i_divisor,
    output logic                               o_busy,
    output logic                               o_done,
    output logic [ppws_pkg::DIV_N_W-1:0]       o_quotient
);

    localparam int NW = ppws_pkg::DIV_N_W;
    localparam int DW = ppws_pkg::DIV_D_W;
    localparam int CW = $clog2(NW);

    // Restoring division, one quotient bit per cycle. r_quo shifts the
    // dividend out at the top and the quotient in at the bottom.
    logic [NW-1:0] r_quo;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_div;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [DW:0]   w_rem_sh;
    logic          w_ge;
    logic [DW:0]   w_diff;

    assign w_rem_sh   = {r_rem, r_quo[NW-1]};
    assign w_ge       = (w_rem_sh >= {1'b0, r_div});
    assign w_diff     = w_rem_sh - {1'b0, r_div};
    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_quo  <= i_dividend;
                r_div  <= i_divisor;
                r_rem  <= '0;
                r_cnt  <= CW'(NW - 1);
            end else if (r_busy) begin
                r_rem <= w_ge ? w_diff[DW-1:0] : w_rem_sh[DW-1:0];
                r_quo <= {r_quo[NW-2:0], w_ge};
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

FILE: hdl/ppws_back.sv
`timescale 1ns / 1ps
`default_nettype none

module ppws_back (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  ppws_pkg::t_job  i_job,
    input  wire logic       i_empty,
    output logic            o_pop,
    input  ppws_pkg::t_cfg  i_cfg,
    ppws_out_if.source      o_wind
);

    localparam int NW = ppws_pkg::DIV_N_W;
    localparam int DW = ppws_pkg::DIV_D_W;
    localparam int PW = ppws_pkg::SCALED_W + ppws_pkg::RECIP_W;

    typedef enum logic [2:0] {
        S_IDLE, S_FREQ, S_WIN, S_MEAN, S_MUL, S_SCALE, S_SPEED, S_OUT
    } t_state;

    t_state                          r_state;
    logic                            r_last;
    logic [ppws_pkg::SUM_W-1:0]      r_sum;
    logic [ppws_pkg::COUNT_W-1:0]    r_count;
    logic [ppws_pkg::MEAN_W-1:0]     r_mean;
    logic [ppws_pkg::SPEED_W-1:0]    r_speed;
    logic [ppws_pkg::ACC_W-1:0]      r_acc;
    logic [ppws_pkg::SCALED_W-1:0]   r_scaled;
    logic                            r_o_valid;
    logic [ppws_pkg::MEAN_W-1:0]     r_o_mean;
    logic [ppws_pkg::SPEED_W-1:0]    r_o_speed;
    logic [ppws_pkg::COUNT_W-1:0]    r_o_count;

    logic                            div_start;
    logic [NW-1:0]                   div_dividend;
    logic [DW-1:0]                   div_divisor;
    logic                            div_busy;
    logic                            div_done;
    logic [NW-1:0]                   div_q;

    logic [ppws_pkg::SUM_W:0]        w_sum_ext;
    logic [ppws_pkg::ACC_W-2:0]      w_prod;
    logic [ppws_pkg::ACC_W+3:0]      w_acc9;
    logic [ppws_pkg::SCALED_W-1:0]   w_scaled;
    logic [PW-1:0]                   w_prod5;
    logic                            w_out_free;

    ppws_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    assign w_sum_ext  = {1'b0, r_sum} + (ppws_pkg::SUM_W+1)'(div_q[ppws_pkg::MEAN_W-1:0]);
    assign w_prod     = r_mean * i_cfg.gain;
    assign w_acc9     = {1'b0, r_acc, 3'b000} + {4'b0000, r_acc};
    assign w_scaled   = w_acc9[ppws_pkg::SCALE_SHIFT +: ppws_pkg::SCALED_W];
    // Divide by five as a reciprocal multiply; the quotient sits above
    // DIV5_SHIFT.
    assign w_prod5    = r_scaled * ppws_pkg::DIV5_RECIP;
    assign w_out_free = !r_o_valid || o_wind.ready;

    assign o_pop = (r_state == S_IDLE) && !i_empty;

    always_comb begin
        div_start    = 1'b0;
        div_dividend = ppws_pkg::FREQ_NUM;
        div_divisor  = i_job.width;
        unique case (r_state)
            S_IDLE: begin
                div_start = !i_empty && i_job.in_range;
            end
            S_WIN: begin
                div_start    = (r_count != '0);
                div_dividend = NW'(r_sum);
                div_divisor  = DW'(r_count);
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_last    <= 1'b0;
            r_sum     <= '0;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (r_o_valid && o_wind.ready && (r_state != S_OUT)) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_last  <= i_job.last;
                        r_state <= i_job.in_range ? S_FREQ : S_WIN;
                    end
                end
                S_FREQ: begin
                    if (div_done) begin
                        r_sum <= w_sum_ext[ppws_pkg::SUM_W] ? '1
                                 : w_sum_ext[ppws_pkg::SUM_W-1:0];
                        if (r_count != '1) begin
                            r_count <= r_count + ppws_pkg::COUNT_W'(1);
                        end
                        r_state <= r_last ? S_WIN : S_IDLE;
                    end
                end
                S_WIN: begin
                    if (r_count == '0) begin
                        r_mean  <= '0;
                        r_speed <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_MEAN;
                    end
                end
                S_MEAN: begin
                    if (div_done) begin
                        r_mean <= (|div_q[NW-1:ppws_pkg::MEAN_W]) ? '1
                                  : div_q[ppws_pkg::MEAN_W-1:0];
                        if (div_q == '0) begin
                            r_speed <= '0;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    r_acc   <= {1'b0, w_prod} + {6'b000000, i_cfg.offset, 16'h0000};
                    r_state <= S_SCALE;
                end
                S_SCALE: begin
                    r_scaled <= w_scaled;
                    r_state  <= S_SPEED;
                end
                S_SPEED: begin
                    r_speed <= (|w_prod5[PW-1:ppws_pkg::DIV5_SHIFT+ppws_pkg::SPEED_W]) ? '1
                               : w_prod5[ppws_pkg::DIV5_SHIFT +: ppws_pkg::SPEED_W];
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_o_valid <= 1'b1;
                        r_o_mean  <= r_mean;
                        r_o_speed <= r_speed;
                        r_o_count <= r_count;
                        r_sum     <= '0;
                        r_count   <= '0;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_wind.valid           = r_o_valid;
    assign o_wind.mean_freq_mhz   = r_o_mean;
    assign o_wind.speed_milli_kmh = r_o_speed;
    assign o_wind.valid_readings  = r_o_count;

    // The shared divider is never restarted while it is still working.
    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    // A window without valid readings reports a zero mean.
    a_empty_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> (r_o_count != '0 || r_o_mean == '0))
        else $error("nonzero mean from an empty window");

    // A zero mean always reports zero speed.
    a_zero_speed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> (r_o_mean != '0 || r_o_speed == '0))
        else $error("speed reported for zero mean");

    // The mean never exceeds the largest valid frequency.
    a_mean_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> (r_o_mean <= ppws_pkg::FREQ_MAX))
        else $error("mean above the valid frequency range");

endmodule

`default_nettype wire

FILE: hdl/pulse_period_wind_speed.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel    Direction  Handshake      Item
// i_pulse    in         valid/ready    pulse_width_us (23 bits, us)
// o_wind     out        valid/ready    mean_freq_mhz, speed_milli_kmh, valid_readings
// APB        in         psel/penable   speed_gain_q16 at 0x0, speed_offset_mm_s at 0x4
//
// A reading within 5000..5000000 us passes through the 29-step restoring
// divider in the back end, which turns the width into mHz.
// Other readings reach the back end only when they close a window.
// Closing a window adds one more pass through the same divider for the mean,
// then a multiply and a reciprocal multiply for the speed; a window that
// held no valid reading skips the divider and both multiplies.
// Reset is synchronous and active low; it restores the register defaults and
// empties the window. A four-entry queue lets input items be taken while the
// back end divides, and a stalled output only holds the back end once the
// next window result is ready.

module pulse_period_wind_speed #(
    parameter int WINDOW_READINGS = ppws_pkg::WINDOW_READINGS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    ppws_in_if.sink                            i_pulse,
    ppws_out_if.source                         o_wind,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ppws_pkg::APB_AW-1:0]   paddr,
    input  wire logic [ppws_pkg::APB_DW-1:0]   pwdata,
    output logic [ppws_pkg::APB_DW-1:0]        prdata,
    output logic                               pready
);

    ppws_pkg::t_cfg r_cfg;
    ppws_pkg::t_job front_job;
    ppws_pkg::t_job queue_job;
    logic           front_push;
    logic           queue_full;
    logic           queue_empty;
    logic           back_pop;
    logic           w_wr;

    // Register file. Writes complete in the access phase; pready is tied
    // high so there are no wait states.
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain   <= ppws_pkg::GAIN_RESET;
            r_cfg.offset <= ppws_pkg::OFFSET_RESET;
        end else if (w_wr) begin
            unique case (paddr[2])
                ppws_pkg::REG_GAIN: begin
                    r_cfg.gain <= pwdata[ppws_pkg::GAIN_W-1:0];
                end
                ppws_pkg::REG_OFFSET: begin
                    r_cfg.offset <= pwdata[ppws_pkg::OFFSET_W-1:0];
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            ppws_pkg::REG_GAIN:   prdata = ppws_pkg::APB_DW'(r_cfg.gain);
            ppws_pkg::REG_OFFSET: prdata = ppws_pkg::APB_DW'(r_cfg.offset);
            default:              prdata = '0;
        endcase
    end

    // The front end tracks the window position and screens out widths that
    // cannot give a valid frequency before they reach the divider.
    ppws_front #(
        .WINDOW_READINGS (WINDOW_READINGS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pulse (i_pulse),
        .i_full  (queue_full),
        .o_job   (front_job),
        .o_push  (front_push)
    );

    ppws_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_job   (front_job),
        .i_pop   (back_pop),
        .o_job   (queue_job),
        .o_full  (queue_full),
        .o_empty (queue_empty)
    );

    // The back end accumulates frequencies and produces the window result.
    ppws_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (queue_job),
        .i_empty (queue_empty),
        .o_pop   (back_pop),
        .i_cfg   (r_cfg),
        .o_wind  (o_wind)
    );

endmodule

`default_nettype wire

FILE: tb/sv/ppws_checker.sv
`timescale 1ns / 1ps

// Watches the pulse and wind channels and the register port, predicts each
// window result and compares the delivered results against it.
module ppws_checker
    import ppws_pkg::*;
#(
    parameter int WINDOW_READINGS = WINDOW_READINGS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    ppws_in_if                       pulse_ch,
    ppws_out_if                      wind_ch,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic                pready,
    input  wire logic [APB_AW-1:0]   paddr,
    input  wire logic [APB_DW-1:0]   pwdata,
    output int                       o_fail_count,
    output int                       o_pending,
    output int                       o_results_checked
);

    typedef struct packed {
        logic [MEAN_W-1:0]  mean_freq_mhz;
        logic [SPEED_W-1:0] speed_milli_kmh;
        logic [COUNT_W-1:0] valid_readings;
    } t_wind_result;

    localparam logic [31:0] SUM_LIMIT   = (32'd1 << SUM_W) - 32'd1;
    localparam logic [31:0] MEAN_LIMIT  = (32'd1 << MEAN_W) - 32'd1;
    localparam logic [63:0] SPEED_LIMIT = (64'd1 << SPEED_W) - 64'd1;
    localparam logic [31:0] FREQ_LOW    = 32'd100;

    t_wind_result        windows_due[$];
    logic [GAIN_W-1:0]   gain_q16   = GAIN_RESET;
    logic [OFFSET_W-1:0] offset_mms = OFFSET_RESET;
    logic [SUM_W-1:0]    freq_sum_mhz;
    logic [COUNT_W-1:0]  valid_in_window;
    int                  readings_in_window;
    int                  fail_total    = 0;
    int                  checked_total = 0;

    initial begin
        o_fail_count      = 0;
        o_pending         = 0;
        o_results_checked = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        fail_total++;
    endtask

    function automatic logic [SPEED_W-1:0] speed_for_mean(input logic [MEAN_W-1:0] mean);
        logic [63:0] acc;
        logic [63:0] scaled;
        if (mean == '0) begin
            return '0;
        end
        acc    = 64'(mean) * 64'(gain_q16) + (64'(offset_mms) << 16);
        scaled = (acc * 64'd36) / 64'd655360;
        if (scaled > SPEED_LIMIT) begin
            return '1;
        end
        return scaled[SPEED_W-1:0];
    endfunction

    task automatic take_reading(input logic [WIDTH_W-1:0] width_us);
        logic [31:0]  freq;
        logic [31:0]  sum;
        logic [31:0]  mean;
        t_wind_result res;
        if (width_us != '0) begin
            freq = 32'(FREQ_NUM) / 32'(width_us);
            if (freq >= FREQ_LOW && freq <= 32'(FREQ_MAX)) begin
                sum = 32'(freq_sum_mhz) + freq;
                freq_sum_mhz = (sum > SUM_LIMIT) ? '1 : sum[SUM_W-1:0];
                if (valid_in_window != '1) begin
                    valid_in_window++;
                end
            end
        end
        readings_in_window++;
        if (readings_in_window >= WINDOW_READINGS) begin
            mean = (valid_in_window != '0) ? 32'(freq_sum_mhz) / 32'(valid_in_window) : 32'd0;
            if (mean > MEAN_LIMIT) begin
                mean = MEAN_LIMIT;
            end
            res.mean_freq_mhz   = mean[MEAN_W-1:0];
            res.speed_milli_kmh = speed_for_mean(mean[MEAN_W-1:0]);
            res.valid_readings  = valid_in_window;
            windows_due.push_back(res);
            freq_sum_mhz       = '0;
            valid_in_window    = '0;
            readings_in_window = 0;
        end
    endtask

    task automatic check_window_result();
        t_wind_result want;
        if (windows_due.size() == 0) begin
            report_mismatch($sformatf("window result with none due: mean %0d speed %0d count %0d",
                wind_ch.mean_freq_mhz, wind_ch.speed_milli_kmh, wind_ch.valid_readings));
            return;
        end
        want = windows_due.pop_front();
        checked_total++;
        if (wind_ch.mean_freq_mhz !== want.mean_freq_mhz) begin
            report_mismatch($sformatf("mean_freq_mhz got %0d, expected %0d",
                wind_ch.mean_freq_mhz, want.mean_freq_mhz));
        end
        if (wind_ch.speed_milli_kmh !== want.speed_milli_kmh) begin
            report_mismatch($sformatf("speed_milli_kmh got %0d, expected %0d",
                wind_ch.speed_milli_kmh, want.speed_milli_kmh));
        end
        if (wind_ch.valid_readings !== want.valid_readings) begin
            report_mismatch($sformatf("valid_readings got %0d, expected %0d",
                wind_ch.valid_readings, want.valid_readings));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            gain_q16           = GAIN_RESET;
            offset_mms         = OFFSET_RESET;
            freq_sum_mhz       = '0;
            valid_in_window    = '0;
            readings_in_window = 0;
            windows_due.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[2])
                    REG_GAIN:   gain_q16   = pwdata[GAIN_W-1:0];
                    REG_OFFSET: offset_mms = pwdata[OFFSET_W-1:0];
                    default: ;
                endcase
            end
            // A result leaving now always belongs to an earlier window than
            // a reading taken at the same edge.
            if (wind_ch.valid && wind_ch.ready) begin
                check_window_result();
            end
            if (pulse_ch.valid && pulse_ch.ready) begin
                take_reading(pulse_ch.pulse_width_us);
            end
        end
        o_fail_count      <= fail_total;
        o_pending         <= windows_due.size();
        o_results_checked <= checked_total;
    end

endmodule

FILE: tb/sv/tb_pulse_period_wind_speed.sv
`timescale 1ns / 1ps

module tb_pulse_period_wind_speed;
    import ppws_pkg::*;

    // The back end can hold four queued readings and a window close, so this
    // many cycles after the last expected result the block is certainly idle.
    localparam int DRAIN_CYCLES      = 300;
    localparam int ITEMS_PER_SETTING = 85;
    localparam int SETTINGS_COUNT    = 8;
    localparam int DIRECTED_COUNT    = 24;
    localparam logic [WIDTH_W-1:0] WIDTH_ALL_ONES = '1;

    // Window modes steer how many readings of a window are in range.
    localparam int MODE_MOSTLY_VALID   = 0;
    localparam int MODE_MOSTLY_INVALID = 1;
    localparam int MODE_ALL_INVALID    = 2;

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    int  fail_count;
    int  pending;
    int  results_checked;
    int  items_sent = 0;
    // While set, neither side inserts idle cycles, so the block runs flat out.
    logic quiet_stretch = 1'b0;

    ppws_in_if  pulse_ch ();
    ppws_out_if wind_ch ();

    // The first window has no reading in range, the second holds the range
    // limits and the third mixes both kinds.
    logic [WIDTH_W-1:0] directed_widths [DIRECTED_COUNT] = '{
        23'd0, 23'd1, 23'd4999, 23'd5000001, WIDTH_ALL_ONES, 23'd2, 23'd4096, 23'd7000000,
        23'd5000, 23'd5000000, 23'd5001, 23'd4999999, 23'd5000, 23'd5000000, 23'd250000,
        23'd12500,
        23'd0, 23'd5000, 23'd4999, 23'd5000001, 23'd1000000, WIDTH_ALL_ONES, 23'd5000, 23'd0
    };

    always #4 i_clk = ~i_clk;

    pulse_period_wind_speed dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pulse (pulse_ch),
        .o_wind  (wind_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    ppws_checker checker_inst (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .pulse_ch          (pulse_ch),
        .wind_ch           (wind_ch),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .pready            (pready),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .o_fail_count      (fail_count),
        .o_pending         (pending),
        .o_results_checked (results_checked)
    );

    // Idle lengths: mostly none or short, now and then a long pause.
    function automatic int idle_len();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            return 0;
        end else if (pick < 85) begin
            return $urandom_range(1, 3);
        end else if (pick < 97) begin
            return $urandom_range(4, 20);
        end
        return $urandom_range(40, 150);
    endfunction

    // In-range widths favor the short end, where the frequency changes
    // fastest, and the limits themselves. Out-of-range widths are split
    // between timeouts, too short, too long and the values just past the limits.
    function automatic logic [WIDTH_W-1:0] random_width(input int mode);
        int unsigned pick;
        int unsigned sub;
        int unsigned valid_share;
        case (mode)
            MODE_MOSTLY_VALID:   valid_share = 80;
            MODE_MOSTLY_INVALID: valid_share = 20;
            default:             valid_share = 0;
        endcase
        pick = $urandom_range(0, 99);
        sub  = $urandom_range(0, 9);
        if (pick < valid_share) begin
            if (sub == 0) begin
                return $urandom_range(0, 1) ? 23'd5000 : 23'd5000000;
            end else if (sub <= 3) begin
                return WIDTH_W'($urandom_range(5000, 50000));
            end else if (sub <= 6) begin
                return WIDTH_W'($urandom_range(5000, 5000 << $urandom_range(0, 9)));
            end
            return WIDTH_W'($urandom_range(5000, 5000000));
        end
        if (sub <= 2) begin
            return '0;
        end else if (sub <= 5) begin
            return WIDTH_W'($urandom_range(1, 4999));
        end else if (sub <= 8) begin
            return WIDTH_W'($urandom_range(5000001, 8388607));
        end
        return $urandom_range(0, 1) ? 23'd4999 : 23'd5000001;
    endfunction

    // Presents one reading after an optional idle gap and returns at the
    // edge where it is accepted. Valid stays high so that a following item
    // with no gap goes out back to back.
    task automatic send_pulse(input logic [WIDTH_W-1:0] width_us);
        int gap;
        gap = quiet_stretch ? 0 : idle_len();
        if (gap > 0) begin
            pulse_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pulse_ch.valid          <= 1'b1;
        pulse_ch.pulse_width_us <= width_us;
        @(posedge i_clk);
        while (!pulse_ch.ready) @(posedge i_clk);
        items_sent++;
    endtask

    // One register write: setup cycle, then access cycle until pready. The
    // trailing edge keeps back-to-back writes from driving psel twice in
    // one time step.
    task automatic write_register(input logic reg_sel, input logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Stops the pulse stream and waits until every due window result has
    // been taken, then lets the back end drain readings that close no window.
    // The first edge lets the pending count catch up with the last reading.
    task automatic wait_idle();
        pulse_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Result side: ready is held high, then dropped for a random stall
    // unless the current stretch runs without idling.
    initial begin
        int stall;
        wind_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            wind_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            stall = quiet_stretch ? 0 : idle_len();
            if (stall > 0) begin
                wind_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
        end
    end

    initial begin
        logic [GAIN_W-1:0]   gain_setting;
        logic [OFFSET_W-1:0] offset_setting;
        int                  mode;

        i_rst_n                 <= 1'b0;
        psel                    <= 1'b0;
        penable                 <= 1'b0;
        pwrite                  <= 1'b0;
        paddr                   <= '0;
        pwdata                  <= '0;
        pulse_ch.valid          <= 1'b0;
        pulse_ch.pulse_width_us <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed windows run on the reset register values, so they also
        // check the defaults.
        foreach (directed_widths[k]) begin
            send_pulse(directed_widths[k]);
        end

        // Each setting gets a batch of random readings. The batch size is
        // not a multiple of the window, so register changes also land in the
        // middle of a window. Setting zero keeps the reset values.
        mode = MODE_MOSTLY_VALID;
        for (int s = 0; s < SETTINGS_COUNT; s++) begin
            case (s)
                0: begin
                    gain_setting   = GAIN_RESET;
                    offset_setting = OFFSET_RESET;
                end
                1: begin
                    gain_setting   = '0;
                    offset_setting = '0;
                end
                2: begin
                    gain_setting   = '1;
                    offset_setting = '1;
                end
                3: begin
                    gain_setting   = '1;
                    offset_setting = '0;
                end
                4: begin
                    gain_setting   = '0;
                    offset_setting = '1;
                end
                7: begin
                    gain_setting   = GAIN_RESET;
                    offset_setting = OFFSET_RESET;
                end
                default: begin
                    gain_setting   = GAIN_W'($urandom_range(0, 1048575));
                    offset_setting = OFFSET_W'($urandom_range(0, 65535));
                end
            endcase
            if (s > 0) begin
                wait_idle();
                write_register(REG_GAIN, APB_DW'(gain_setting));
                write_register(REG_OFFSET, APB_DW'(offset_setting));
            end
            for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
                // A new window picks how many of its readings are in range,
                // including windows with none at all, and whether it runs
                // without idle cycles.
                if (items_sent % WINDOW_READINGS_DEF == 0) begin
                    case ($urandom_range(0, 9))
                        0:       mode = MODE_ALL_INVALID;
                        1, 2:    mode = MODE_MOSTLY_INVALID;
                        default: mode = MODE_MOSTLY_VALID;
                    endcase
                    quiet_stretch <= ($urandom_range(0, 5) == 0);
                end
                send_pulse(random_width(mode));
            end
        end

        quiet_stretch <= 1'b0;
        wait_idle();

        $display("tb: %0d pulse widths sent under %0d register settings",
            items_sent, SETTINGS_COUNT);
        $display("tb: %0d window results compared, from empty windows to full-range readings",
            results_checked);
        if (pending != 0) begin
            $display("tb: %0d window results never arrived", pending);
        end
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // The worst case run stays well inside this limit.
    initial begin
        #8000000;
        $display("tb: failure");
        $finish;
    end

endmodule
